### rtl/core/fit_policy_heap_allocator_macros.svh
// Assertion macros shared by the heap allocator RTL.
`ifndef FIT_POLICY_HEAP_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_HEAP_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define FPHA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define FPHA_NEVER(lbl, clk, rst_n, cond, msg) \
  `FPHA_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define FPHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FPHA_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### rtl/core/fpha_pkg.sv
// Types and fixed constants of the heap allocator.
`default_nettype none
package fpha_pkg;

  localparam int ADDR_W  = 48;
  localparam int REQ_W   = 21;
  localparam int HSIZE_W = 21;
  localparam int STAT_W  = 3;
  localparam int MODE_W  = 2;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;
  // Width of size compares with headroom for size plus header
  localparam int CW      = 22;

  localparam logic [HSIZE_W-1:0] HSIZE_MIN = 21'd64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 2'd2;

  localparam logic [1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [1:0] REG_HEAP_BASE = 2'd1;
  localparam logic [1:0] REG_HEAP_SIZE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ALREADY = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOTBLK  = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_FCHK,
    ST_SCAN,
    ST_TAKE,
    ST_SHUP,
    ST_WR_A,
    ST_WR_B,
    ST_FNXT_RD,
    ST_FNXT_EV,
    ST_FMERGE,
    ST_SHDN,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

### rtl/core/fpha_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/core/fit_policy_heap_allocator.sv
// Top level of the best/worst/next fit heap allocator.
//
//   channel   direction  handshake                  payload
//   cfg       in         psel/penable/pwrite/pready paddr, pwdata, prdata
//   in        in         in_valid_i / in_stall_o    command, request_bytes, free_address
//   out       out        out_valid_o / out_stall_i  block_address, status
//
// One item at a time: the sequencer walks the segment table through a single
// RAM read port, one entry per cycle, then shifts entries one per cycle.
// Best or worst fit allocate scans every entry; a split moves any entries above
// the pick up first, then writes the pick and the free remainder. Free scans to
// the block, reads the next entry if any, merges and moves entries down as needed.
// Reset and a heap_base or heap_size write rebuild the table in ST_INIT.
`default_nettype none
`include "fit_policy_heap_allocator_macros.svh"
module fit_policy_heap_allocator
  import fpha_pkg::*;
#(
  parameter int HDR_BYTES      = 32,
  parameter int MAX_SEGMENTS   = 64,
  parameter int HEAP_MAX_BYTES = 1048576
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [REQ_W-1:0]    request_bytes_i,
  input  logic [ADDR_W-1:0]   free_address_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ADDR_W-1:0]   block_address_o,
  output logic [STAT_W-1:0]   status_o
);

  localparam int IW  = $clog2(MAX_SEGMENTS);
  localparam int CNW = $clog2(MAX_SEGMENTS + 1);
  localparam int CNX = CNW + 1;
  localparam int SW  = $clog2(HEAP_MAX_BYTES + 1);
  localparam int EW  = 2 * SW + 1;
  localparam logic [CW-1:0]      HDR_C    = CW'(HDR_BYTES);
  localparam logic [CNW-1:0]     MAX_C    = CNW'(MAX_SEGMENTS);
  localparam logic [HSIZE_W-1:0] HMAX_C   = HSIZE_W'(HEAP_MAX_BYTES);

  // Configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [ADDR_W-1:0]  base_q;
  logic [HSIZE_W-1:0] hsize_q;

  // Sequencer and datapath registers
  state_e             st_q, st_d;
  logic               cmd_q, cmd_d;
  logic [REQ_W-1:0]   req_q, req_d;
  logic [ADDR_W-1:0]  faddr_q, faddr_d;
  logic [ADDR_W-1:0]  rel_q, rel_d;
  logic [CNW-1:0]     count_q, count_d;
  logic [IW-1:0]      cursor_q, cursor_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic [CNW-1:0]     scan_k_q, scan_k_d;
  logic               ev_vld_q, ev_vld_d;
  logic [IW-1:0]      ev_idx_q, ev_idx_d;
  logic               found_q, found_d;
  logic [IW-1:0]      pick_idx_q, pick_idx_d;
  logic [SW-1:0]      pick_off_q, pick_off_d;
  logic [SW-1:0]      pick_size_q, pick_size_d;
  logic               pick_free_q, pick_free_d;
  logic [SW-1:0]      prev_off_q, prev_off_d;
  logic [SW-1:0]      prev_size_q, prev_size_d;
  logic               prev_free_q, prev_free_d;
  logic [SW-1:0]      nxt_size_q, nxt_size_d;
  logic               nxt_free_q, nxt_free_d;
  logic [IW-1:0]      sh_j_q, sh_j_d;
  logic [IW-1:0]      sh_end_q, sh_end_d;
  logic [IW-1:0]      sh_wr_q, sh_wr_d;
  logic [1:0]         sh_amt_q, sh_amt_d;
  logic               sh_iss_q, sh_iss_d;
  logic               sh_pnd_q, sh_pnd_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [STAT_W-1:0]  res_stat_q, res_stat_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [STAT_W-1:0]  out_stat_q, out_stat_d;

  // RAM port
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic [IW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;
  logic [SW-1:0]      r_off;
  logic [SW-1:0]      r_size;
  logic               r_free;

  // Configuration write decode
  logic               cfg_wr;
  logic [1:0]         cfg_idx;
  logic [HSIZE_W-1:0] cfg_size_raw;
  logic [HSIZE_W-1:0] cfg_size;

  // Scratch
  logic               first_mode;
  logic               issue;
  logic               take_ev;
  logic               cand;
  logic               better;
  logic               hit;
  logic               start_scan;
  logic               split;
  logic               pmerge;
  logic [CW-1:0]      merged;
  logic [CNX-1:0]     dst;
  logic [CNX-1:0]     src;
  logic [1:0]         samt;
  logic [ADDR_W:0]    top;
  logic [ADDR_W-1:0]  rel;

  fpha_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign r_off  = ram_rdata[EW-1 -: SW];
  assign r_size = ram_rdata[SW:1];
  assign r_free = ram_rdata[0];

  // APB decode and saturation of the heap size
  assign pready       = 1'b1;
  assign cfg_wr       = psel & penable & pwrite;
  assign cfg_idx      = paddr[4:3];
  assign cfg_size_raw = pwdata[HSIZE_W-1:0];

  always_comb begin
    cfg_size = cfg_size_raw;
    if (cfg_size_raw < HSIZE_MIN) begin
      cfg_size = HSIZE_MIN;
    end else if (cfg_size_raw > HMAX_C) begin
      cfg_size = HMAX_C;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FIT_MODE:  prdata = PDATA_W'(mode_q);
      REG_HEAP_BASE: prdata = PDATA_W'(base_q);
      REG_HEAP_SIZE: prdata = PDATA_W'(hsize_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BEST;
      base_q  <= '0;
      hsize_q <= HMAX_C;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FIT_MODE:  mode_q  <= pwdata[MODE_W-1:0];
        REG_HEAP_BASE: base_q  <= pwdata[ADDR_W-1:0];
        REG_HEAP_SIZE: hsize_q <= cfg_size;
        default:       mode_q  <= mode_q;
      endcase
    end
  end

  assign in_stall_o      = (st_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign block_address_o = out_addr_q;
  assign status_o        = out_stat_q;

  // Scan helpers
  assign first_mode = (cmd_q == CMD_FREE) || (mode_q == MODE_NEXT);
  assign cand       = r_free && (CW'(r_size) >= CW'(req_q));
  assign hit        = (ADDR_W'(r_off) == rel_q);
  assign take_ev    = ev_vld_q && !(first_mode && found_q);
  assign top        = {1'b0, base_q} + (ADDR_W + 1)'(hsize_q);
  assign rel        = faddr_q - base_q;
  assign split      = (CW'(pick_size_q) > CW'(req_q) + HDR_C) && (count_q < MAX_C);
  assign pmerge     = (pick_idx_q != '0) && prev_free_q;
  assign merged     = CW'(pick_size_q) + (nxt_free_q ? CW'(nxt_size_q) + HDR_C : '0);

  always_comb begin
    if (first_mode) begin
      better = !found_q;
    end else if (mode_q == MODE_WORST) begin
      better = !found_q || (r_size > pick_size_q);
    end else begin
      better = !found_q || (r_size < pick_size_q);
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    faddr_d     = faddr_q;
    rel_d       = rel_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    rd_idx_d    = rd_idx_q;
    scan_k_d    = scan_k_q;
    ev_vld_d    = 1'b0;
    ev_idx_d    = rd_idx_q;
    found_d     = found_q;
    pick_idx_d  = pick_idx_q;
    pick_off_d  = pick_off_q;
    pick_size_d = pick_size_q;
    pick_free_d = pick_free_q;
    prev_off_d  = prev_off_q;
    prev_size_d = prev_size_q;
    prev_free_d = prev_free_q;
    nxt_size_d  = nxt_size_q;
    nxt_free_d  = nxt_free_q;
    sh_j_d      = sh_j_q;
    sh_end_d    = sh_end_q;
    sh_wr_d     = sh_wr_q;
    sh_amt_d    = sh_amt_q;
    sh_iss_d    = sh_iss_q;
    sh_pnd_d    = 1'b0;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = rd_idx_q;
    issue       = 1'b0;
    start_scan  = 1'b0;
    dst         = '0;
    samt        = '0;
    src         = '0;

    case (st_q)
      ST_INIT: begin
        // Rebuild the table as one free segment
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {SW'(0), SW'(hsize_q - HSIZE_W'(HDR_BYTES)), 1'b1};
        count_d   = CNW'(1);
        cursor_d  = '0;
        st_d      = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = command_i;
          req_d      = request_bytes_i;
          faddr_d    = free_address_i;
          res_addr_d = '0;
          rd_idx_d   = '0;
          if (command_i == CMD_FREE) begin
            st_d = ST_FCHK;
          end else if (request_bytes_i == '0) begin
            res_stat_d = STAT_ZERO;
            st_d       = ST_DONE;
          end else begin
            start_scan = 1'b1;
            if (mode_q == MODE_NEXT && CNW'(cursor_q) < count_q) begin
              rd_idx_d = cursor_q;
            end
          end
        end
      end

      ST_FCHK: begin
        // Range check in bytes, then strip the header
        if (faddr_q < base_q || {1'b0, faddr_q} > top) begin
          res_stat_d = STAT_OUTSIDE;
          st_d       = ST_DONE;
        end else if (rel < ADDR_W'(HDR_BYTES)) begin
          res_stat_d = STAT_NOTBLK;
          st_d       = ST_DONE;
        end else begin
          rel_d      = rel - ADDR_W'(HDR_BYTES);
          start_scan = 1'b1;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, evaluate the entry read last cycle
        issue     = (scan_k_q < count_q) && !(first_mode && found_q);
        ram_raddr = rd_idx_q;
        if (issue) begin
          ev_vld_d = 1'b1;
          ev_idx_d = rd_idx_q;
          scan_k_d = scan_k_q + CNW'(1);
          rd_idx_d = (CNW'(rd_idx_q) + CNW'(1) == count_q) ? '0 : rd_idx_q + IW'(1);
        end
        if (take_ev) begin
          if (cmd_q == CMD_FREE) begin
            if (hit) begin
              found_d     = 1'b1;
              pick_idx_d  = ev_idx_q;
              pick_off_d  = r_off;
              pick_size_d = r_size;
              pick_free_d = r_free;
            end else begin
              prev_off_d  = r_off;
              prev_size_d = r_size;
              prev_free_d = r_free;
            end
          end else if (cand && better) begin
            found_d     = 1'b1;
            pick_idx_d  = ev_idx_q;
            pick_off_d  = r_off;
            pick_size_d = r_size;
          end
        end
        if ((first_mode && found_q) || (scan_k_q == count_q && !ev_vld_q)) begin
          if (cmd_q == CMD_ALLOC) begin
            if (found_q) begin
              st_d = ST_TAKE;
            end else begin
              res_stat_d = STAT_NOFIT;
              st_d       = ST_DONE;
            end
          end else if (!found_q) begin
            res_stat_d = STAT_NOTBLK;
            st_d       = ST_DONE;
          end else if (pick_free_q) begin
            res_stat_d = STAT_ALREADY;
            st_d       = ST_DONE;
          end else if (CNW'(pick_idx_q) + CNW'(1) < count_q) begin
            st_d = ST_FNXT_RD;
          end else begin
            nxt_free_d = 1'b0;
            st_d       = ST_FMERGE;
          end
        end
      end

      ST_TAKE: begin
        res_addr_d = base_q + ADDR_W'(pick_off_q) + ADDR_W'(HDR_BYTES);
        res_stat_d = STAT_OK;
        if (split) begin
          if (CNW'(pick_idx_q) + CNW'(1) < count_q) begin
            sh_j_d   = IW'(count_q - CNW'(1));
            sh_end_d = pick_idx_q + IW'(1);
            sh_iss_d = 1'b1;
            st_d     = ST_SHUP;
          end else begin
            st_d = ST_WR_A;
          end
        end else begin
          // Take the segment whole
          ram_we    = 1'b1;
          ram_waddr = pick_idx_q;
          ram_wdata = {pick_off_q, pick_size_q, 1'b0};
          if (mode_q == MODE_NEXT) begin
            cursor_d = pick_idx_q;
          end
          st_d = ST_DONE;
        end
      end

      ST_SHUP: begin
        // Move entries up by one, top first
        ram_raddr = sh_j_q;
        if (sh_iss_q) begin
          sh_pnd_d = 1'b1;
          sh_wr_d  = sh_j_q + IW'(1);
          if (sh_j_q == sh_end_q) begin
            sh_iss_d = 1'b0;
          end else begin
            sh_j_d = sh_j_q - IW'(1);
          end
        end
        if (sh_pnd_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wr_q;
          ram_wdata = ram_rdata;
        end
        if (!sh_iss_q) begin
          st_d = ST_WR_A;
        end
      end

      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx_q;
        ram_wdata = {pick_off_q, SW'(req_q), 1'b0};
        st_d      = ST_WR_B;
      end

      ST_WR_B: begin
        // Free remainder after the split
        ram_we    = 1'b1;
        ram_waddr = pick_idx_q + IW'(1);
        ram_wdata = {SW'(CW'(pick_off_q) + HDR_C + CW'(req_q)),
                     SW'(CW'(pick_size_q) - HDR_C - CW'(req_q)), 1'b1};
        count_d   = count_q + CNW'(1);
        cursor_d  = pick_idx_q + IW'(1);
        st_d      = ST_DONE;
      end

      ST_FNXT_RD: begin
        ram_raddr = pick_idx_q + IW'(1);
        st_d      = ST_FNXT_EV;
      end

      ST_FNXT_EV: begin
        nxt_size_d = r_size;
        nxt_free_d = r_free;
        st_d       = ST_FMERGE;
      end

      ST_FMERGE: begin
        // Coalesce with free neighbors and plan the removal of merged entries
        ram_we     = 1'b1;
        res_stat_d = STAT_OK;
        if (pmerge) begin
          ram_waddr = pick_idx_q - IW'(1);
          ram_wdata = {prev_off_q, SW'(CW'(prev_size_q) + HDR_C + merged), 1'b1};
          dst       = CNX'(pick_idx_q);
          samt      = 2'd1 + 2'(nxt_free_q);
          cursor_d  = pick_idx_q - IW'(1);
        end else begin
          ram_waddr = pick_idx_q;
          ram_wdata = {pick_off_q, SW'(merged), 1'b1};
          dst       = CNX'(pick_idx_q) + CNX'(1);
          samt      = 2'(nxt_free_q);
          cursor_d  = pick_idx_q;
        end
        src      = dst + CNX'(samt);
        count_d  = count_q - CNW'(samt);
        sh_amt_d = samt;
        if (samt != '0 && src < CNX'(count_q)) begin
          sh_j_d   = IW'(src);
          sh_end_d = IW'(count_q - CNW'(1));
          sh_iss_d = 1'b1;
          st_d     = ST_SHDN;
        end else begin
          st_d = ST_DONE;
        end
      end

      ST_SHDN: begin
        // Move entries down over the removed ones, bottom first
        ram_raddr = sh_j_q;
        if (sh_iss_q) begin
          sh_pnd_d = 1'b1;
          sh_wr_d  = sh_j_q - IW'(sh_amt_q);
          if (sh_j_q == sh_end_q) begin
            sh_iss_d = 1'b0;
          end else begin
            sh_j_d = sh_j_q + IW'(1);
          end
        end
        if (sh_pnd_q) begin
          ram_we    = 1'b1;
          ram_waddr = sh_wr_q;
          ram_wdata = ram_rdata;
        end
        if (!sh_iss_q) begin
          st_d = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_stat_d  = res_stat_q;
          st_d        = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (start_scan) begin
      scan_k_d    = '0;
      found_d     = 1'b0;
      prev_free_d = 1'b0;
      st_d        = ST_SCAN;
    end

    // Heap reconfiguration rebuilds the table
    if (cfg_wr && (cfg_idx == REG_HEAP_BASE || cfg_idx == REG_HEAP_SIZE)) begin
      st_d = ST_INIT;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_INIT;
      count_q     <= CNW'(1);
      cursor_q    <= '0;
      ev_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      sh_iss_q    <= 1'b0;
      sh_pnd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      ev_vld_q    <= ev_vld_d;
      found_q     <= found_d;
      sh_iss_q    <= sh_iss_d;
      sh_pnd_q    <= sh_pnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    faddr_q     <= faddr_d;
    rel_q       <= rel_d;
    rd_idx_q    <= rd_idx_d;
    scan_k_q    <= scan_k_d;
    ev_idx_q    <= ev_idx_d;
    pick_idx_q  <= pick_idx_d;
    pick_off_q  <= pick_off_d;
    pick_size_q <= pick_size_d;
    pick_free_q <= pick_free_d;
    prev_off_q  <= prev_off_d;
    prev_size_q <= prev_size_d;
    prev_free_q <= prev_free_d;
    nxt_size_q  <= nxt_size_d;
    nxt_free_q  <= nxt_free_d;
    sh_j_q      <= sh_j_d;
    sh_end_q    <= sh_end_d;
    sh_wr_q     <= sh_wr_d;
    sh_amt_q    <= sh_amt_d;
    res_addr_q  <= res_addr_d;
    res_stat_q  <= res_stat_d;
    out_addr_q  <= out_addr_d;
    out_stat_q  <= out_stat_d;
  end

  // Checks on the sequencer and table bookkeeping
  `FPHA_ASSERT(a_count_range, clk_i, rst_ni,
    (count_q != '0) && (count_q <= MAX_C), "segment count out of range")
  `FPHA_ASSERT(a_cursor_in_table, clk_i, rst_ni,
    (st_q == ST_IDLE) |-> (CNW'(cursor_q) < count_q), "cursor beyond table")
  `FPHA_ASSERT(a_result_from_done, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(st_q) == ST_DONE), "result without completion")
  `FPHA_NEVER(a_fail_has_addr, clk_i, rst_ni,
    out_valid_q && (out_stat_q != STAT_OK) && (out_addr_q != '0), "address on failed result")

endmodule
`default_nettype wire

### verif/tb_fit_policy_heap_allocator.sv
// Self-checking testbench for the fit-policy heap allocator.
`timescale 1ns / 1ps
module tb_fit_policy_heap_allocator;
  import fpha_pkg::*;

  localparam int HDR = 32;
  localparam int NSEG = 64;
  localparam int HMAX = 1048576;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] stat;
  } alloc_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = CMD_ALLOC;
  logic [REQ_W-1:0] request_bytes_i = '0;
  logic [ADDR_W-1:0] free_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ADDR_W-1:0] block_address_o;
  logic [STAT_W-1:0] status_o;

  fit_policy_heap_allocator DUT (.*);

  always #6 clk_i = ~clk_i;

  // Shadow allocator state
  logic [MODE_W-1:0] sh_mode;
  logic [ADDR_W-1:0] sh_base;
  int unsigned sh_hsize;
  int unsigned seg_off [NSEG];
  int unsigned seg_sz [NSEG];
  bit seg_free [NSEG];
  int unsigned seg_cnt, cursor;

  alloc_result_t pending_results[$];
  logic [ADDR_W-1:0] live_blocks[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit rx_stall_on = 1'b1;

  function automatic void rebuild_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_off[i] = 0; seg_sz[i] = 0; seg_free[i] = 0;
    end
    seg_sz[0] = (sh_hsize > HDR) ? sh_hsize - HDR : 0;
    seg_free[0] = 1;
    seg_cnt = 1;
    cursor = 0;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned i = idx; i + 1 < seg_cnt; i++) begin
      seg_off[i] = seg_off[i+1]; seg_sz[i] = seg_sz[i+1]; seg_free[i] = seg_free[i+1];
    end
    seg_cnt--;
  endfunction

  function automatic alloc_result_t predict_alloc(int unsigned bytes);
    alloc_result_t r;
    int unsigned i, pick;
    bit found;
    r = '0;
    pick = 0; found = 0;
    if (bytes == 0) begin
      r.stat = STAT_ZERO;
      return r;
    end
    if (sh_mode == MODE_NEXT) begin
      i = (cursor < seg_cnt) ? cursor : 0;
      for (int unsigned k = 0; k < seg_cnt; k++) begin
        if (seg_free[i] && seg_sz[i] >= bytes) begin
          pick = i; found = 1; break;
        end
        i++;
        if (i >= seg_cnt) i = 0;
      end
    end else begin
      for (i = 0; i < seg_cnt; i++) begin
        if (!seg_free[i] || seg_sz[i] < bytes) continue;
        if (!found || (sh_mode == MODE_WORST ? seg_sz[i] > seg_sz[pick]
                                             : seg_sz[i] < seg_sz[pick])) begin
          pick = i; found = 1;
        end
      end
    end
    if (!found) begin
      r.stat = STAT_NOFIT;
      return r;
    end
    seg_free[pick] = 0;
    if (seg_sz[pick] > bytes + HDR && seg_cnt < NSEG) begin
      for (i = seg_cnt; i > pick + 1; i--) begin
        seg_off[i] = seg_off[i-1]; seg_sz[i] = seg_sz[i-1]; seg_free[i] = seg_free[i-1];
      end
      seg_off[pick+1] = seg_off[pick] + HDR + bytes;
      seg_sz[pick+1] = seg_sz[pick] - HDR - bytes;
      seg_free[pick+1] = 1;
      seg_sz[pick] = bytes;
      seg_cnt++;
      cursor = pick + 1;
    end else if (sh_mode == MODE_NEXT) begin
      cursor = pick;
    end
    r.addr = sh_base + ADDR_W'(seg_off[pick]) + ADDR_W'(HDR);
    r.stat = STAT_OK;
    return r;
  endfunction

  function automatic alloc_result_t predict_free(logic [ADDR_W-1:0] a);
    alloc_result_t r;
    logic [63:0] top, rel;
    int unsigned idx;
    bit found;
    r = '0;
    idx = 0; found = 0;
    top = 64'(sh_base) + 64'(sh_hsize);
    if (64'(a) < 64'(sh_base) || 64'(a) > top) begin
      r.stat = STAT_OUTSIDE;
      return r;
    end
    rel = 64'(a) - 64'(sh_base);
    if (rel < HDR) begin
      r.stat = STAT_NOTBLK;
      return r;
    end
    rel -= HDR;
    for (int unsigned i = 0; i < seg_cnt; i++)
      if (64'(seg_off[i]) == rel) begin
        idx = i; found = 1; break;
      end
    if (!found) begin
      r.stat = STAT_NOTBLK;
      return r;
    end
    if (seg_free[idx]) begin
      r.stat = STAT_ALREADY;
      return r;
    end
    seg_free[idx] = 1;
    cursor = idx;
    if (idx + 1 < seg_cnt && seg_free[idx+1]) begin
      seg_sz[idx] += seg_sz[idx+1] + HDR;
      drop_entry(idx + 1);
    end
    if (idx > 0 && seg_free[idx-1]) begin
      seg_sz[idx-1] += seg_sz[idx] + HDR;
      drop_entry(idx);
      cursor = idx - 1;
    end
    r.stat = STAT_OK;
    return r;
  endfunction

  // Wait for all results, then let any trailing work settle
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * NSEG + 20) @(posedge clk_i);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    logic [63:0] v;
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 3'b000}); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FIT_MODE: sh_mode = value[1:0];
      REG_HEAP_BASE: begin
        sh_base = value[ADDR_W-1:0]; rebuild_table(); live_blocks.delete();
      end
      REG_HEAP_SIZE: begin
        v = value & 64'h1FFFFF;
        if (v < 64) v = 64;
        if (v > HMAX) v = HMAX;
        sh_hsize = v[31:0]; rebuild_table(); live_blocks.delete();
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one command and record its expected result at the transfer
  task automatic send_cmd(logic cmd, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] a);
    alloc_result_t r;
    in_valid_i <= 1'b1;
    command_i <= cmd; request_bytes_i <= bytes; free_address_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = (cmd == CMD_ALLOC) ? predict_alloc(bytes) : predict_free(a);
    pending_results.push_back(r);
    if (cmd == CMD_ALLOC && r.stat == STAT_OK) live_blocks.push_back(r.addr);
    begin
      int unsigned g;
      g = pick_gap();
      if (g != 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  endtask

  task automatic release_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic free_random_live();
    int unsigned k;
    logic [ADDR_W-1:0] a;
    k = $urandom_range(0, live_blocks.size() - 1);
    a = live_blocks[k];
    live_blocks.delete(k);
    send_cmd(CMD_FREE, '0, a);
  endtask

  // Directed: field extremes and each status code
  task automatic test_directed();
    write_reg(REG_FIT_MODE, MODE_BEST);
    send_cmd(CMD_ALLOC, '0, '0);
    send_cmd(CMD_ALLOC, 21'h1FFFFF, '0);
    send_cmd(CMD_ALLOC, 21'd1, '0);
    send_cmd(CMD_ALLOC, 21'd100, '0);
    send_cmd(CMD_FREE, '0, 48'hFFFF_FFFF_FFFF);
    send_cmd(CMD_FREE, '0, 48'd0);
    send_cmd(CMD_FREE, '0, 48'd33);
    send_cmd(CMD_FREE, '0, 48'd32);
    send_cmd(CMD_FREE, '0, 48'd32);
    send_cmd(CMD_FREE, '0, 48'(HMAX));
    send_cmd(CMD_FREE, '0, 48'(HMAX + 1));
    send_cmd(CMD_ALLOC, 21'(HMAX - HDR), '0);
    send_cmd(CMD_FREE, '0, 48'd32);
    release_idle();
    write_reg(REG_HEAP_SIZE, 64'd0);
    send_cmd(CMD_ALLOC, 21'd32, '0);
    send_cmd(CMD_ALLOC, 21'd1, '0);
    release_idle();
    write_reg(REG_HEAP_BASE, 64'hFFFF_FFFF_FFF0);
    write_reg(REG_HEAP_SIZE, 64'h1F_FFFF);
    send_cmd(CMD_ALLOC, 21'd8, '0);
    send_cmd(CMD_FREE, '0, 48'hFFFF_FFFF_FFEF);
    send_cmd(CMD_FREE, '0, 48'h0000_0000_0010);
    release_idle();
    write_reg(3, 64'hFFFF);
  endtask

  // Random phase under one setting: mostly allocate/free of live blocks
  task automatic test_random_phase(logic [1:0] mode, logic [63:0] base,
                                   logic [63:0] hsize, int n, int unsigned max_req);
    int unsigned p;
    logic [ADDR_W-1:0] a;
    release_idle();
    write_reg(REG_FIT_MODE, mode);
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_HEAP_SIZE, hsize);
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 50)
        send_cmd(CMD_ALLOC, REQ_W'($urandom_range(1, max_req)), '0);
      else if (p < 85 && live_blocks.size() != 0)
        free_random_live();
      else if (p < 90)
        send_cmd(CMD_ALLOC, REQ_W'($urandom), '0);
      else if (p < 95) begin
        a = {$urandom, $urandom};
        send_cmd(CMD_FREE, REQ_W'($urandom), a);
      end else begin
        a = sh_base + ADDR_W'($urandom_range(0, sh_hsize + 8));
        send_cmd(CMD_FREE, '0, a);
      end
    end
  endtask

  // Receiver: random stall and result compare
  always @(posedge clk_i) begin
    alloc_result_t exp_r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result addr=%h status=%0d", block_address_o, status_o);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r.addr !== block_address_o || exp_r.stat !== status_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: expected addr=%h status=%0d, got addr=%h status=%0d",
                       exp_r.addr, exp_r.stat, block_address_o, status_o);
          end
        end
      end
      out_stall_i <= rx_stall_on ? ($urandom_range(0, 99) < 25) : 1'b0;
    end
  end

  // Alternate stretches with and without receiver stall
  always begin
    repeat ($urandom_range(50, 400)) @(posedge clk_i);
    rx_stall_on = ~rx_stall_on;
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_fit_policy_heap_allocator failed");
      $finish;
    end
  end

  initial begin
    sh_mode = MODE_BEST; sh_base = '0; sh_hsize = HMAX;
    rebuild_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);
    test_directed();
    test_random_phase(MODE_BEST, 64'h0, 64'd4096, 110, 300);
    test_random_phase(MODE_WORST, 64'h1234_5678_9ABC, 64'd2048, 110, 200);
    test_random_phase(MODE_NEXT, 64'hFFFF_FFFF_F000, 64'd64, 40, 40);
    test_random_phase(MODE_NEXT, 64'h10_0000, 64'(HMAX), 120, 40000);
    test_random_phase(2'd3, 64'h8000, 64'd1000, 80, 120);
    test_random_phase(MODE_WORST, 64'hFFFF_FFFF_FFFF, 64'd512, 60, 60);
    release_idle();
    drain();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_fit_policy_heap_allocator passed");
    else
      $display("tb_fit_policy_heap_allocator failed");
    $finish;
  end

endmodule
